@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands for the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is held.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked assertion that also runs through reset.
`define ASSERT_CLK_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/tcv_pkg.sv @@
// ----------------------------------------------------------------------------
// tcv_pkg
// Shared widths, class codes, register indexes and types of the track vote.
// ----------------------------------------------------------------------------
package tcv_pkg;

    localparam int WINDOW_DEF = 8;

    localparam int CFG_W     = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CLS_W     = 3;
    localparam int NUM_CLASS = 5;

    typedef logic [CFG_W-1:0]     t_tick;
    typedef logic [CLS_W-1:0]     t_cls;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_tick CONFIRM_RST = 8'd5;
    localparam t_tick HOLD_RST    = 8'd30;

    localparam t_cfg_idx CFG_CONFIRM = 2'd0;
    localparam t_cfg_idx CFG_HOLD    = 2'd1;

    localparam t_cls CLS_NONE = 3'd0;
    localparam t_cls CLS_OK   = 3'd1;
    localparam t_cls CLS_VEST = 3'd2;
    localparam t_cls CLS_HAT  = 3'd3;
    localparam t_cls CLS_BOTH = 3'd4;

    // status from the vote unit back to the track sequencer
    typedef struct packed {
        logic busy;
        logic done;
        t_cls pick;
    } t_vote_status;

endpackage

@@ rtl/tcv_ring.sv @@
// ----------------------------------------------------------------------------
// tcv_ring
// Ring of recent class codes: one write port, one read port, bulk clear.
// ----------------------------------------------------------------------------
module tcv_ring #(
    parameter int WINDOW = tcv_pkg::WINDOW_DEF,
    parameter int PTR_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_clr,
    input  logic             i_we,
    input  logic [PTR_W-1:0] i_waddr,
    input  tcv_pkg::t_cls    i_wdata,
    input  logic [PTR_W-1:0] i_raddr,
    output tcv_pkg::t_cls    o_rdata
);
    import tcv_pkg::*;

    t_cls r_slot [WINDOW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            for (int k = 0; k < WINDOW; k++) begin
                r_slot[k] <= CLS_NONE;
            end
        end else if (i_we) begin
            r_slot[i_waddr] <= i_wdata;
        end
    end

    assign o_rdata = r_slot[i_raddr];

endmodule

@@ rtl/tcv_vote.sv @@
// ----------------------------------------------------------------------------
// tcv_vote
// Majority vote: walks the ring one slot a cycle into five class counters,
// then walks the counters with one comparator; a tie keeps the lower code.
// ----------------------------------------------------------------------------
module tcv_vote #(
    parameter int WINDOW = tcv_pkg::WINDOW_DEF,
    parameter int PTR_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  tcv_pkg::t_cls         i_rdata,
    output logic [PTR_W-1:0]      o_raddr,
    output tcv_pkg::t_vote_status o_status
);
    import tcv_pkg::*;

    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(WINDOW - 1);
    localparam t_cls LAST_CLS = CLS_W'(NUM_CLASS - 1);

    typedef enum logic [3:0] {
        V_IDLE  = 4'b0001,
        V_COUNT = 4'b0010,
        V_PICK  = 4'b0100,
        V_DONE  = 4'b1000
    } t_vstate;

    t_vstate          r_state, n_state;
    logic [CNT_W-1:0] r_cnt [NUM_CLASS];
    logic [CNT_W-1:0] n_cnt [NUM_CLASS];
    logic [PTR_W-1:0] r_idx, n_idx;
    t_cls             r_cls, n_cls;
    logic [CNT_W-1:0] r_best, n_best;
    t_cls             r_pick, n_pick;

    t_cls             sel_cls;
    logic [CNT_W-1:0] sel_cnt;
    logic [CNT_W-1:0] inc_cnt;

    // one counter is selected per cycle: by the slot code while counting,
    // by the walk code while picking
    always_comb begin
        sel_cls = (r_state == V_COUNT) ? i_rdata : r_cls;
        sel_cnt = '0;
        for (int k = 0; k < NUM_CLASS; k++) begin
            if (sel_cls == CLS_W'(k)) begin
                sel_cnt = r_cnt[k];
            end
        end
        inc_cnt = sel_cnt + CNT_W'(1);
    end

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_cls   = r_cls;
        n_best  = r_best;
        n_pick  = r_pick;
        for (int k = 0; k < NUM_CLASS; k++) begin
            n_cnt[k] = r_cnt[k];
        end
        case (r_state)
            V_IDLE: begin
                if (i_start) begin
                    for (int k = 0; k < NUM_CLASS; k++) begin
                        n_cnt[k] = '0;
                    end
                    n_idx   = '0;
                    n_state = V_COUNT;
                end
            end
            V_COUNT: begin
                for (int k = 0; k < NUM_CLASS; k++) begin
                    if (i_rdata == CLS_W'(k)) begin
                        n_cnt[k] = inc_cnt;
                    end
                end
                if (r_idx == LAST_IDX) begin
                    n_cls   = CLS_NONE;
                    n_best  = '0;
                    n_pick  = CLS_NONE;
                    n_state = V_PICK;
                end else begin
                    n_idx = r_idx + PTR_W'(1);
                end
            end
            V_PICK: begin
                if (sel_cnt > r_best) begin
                    n_best = sel_cnt;
                    n_pick = r_cls;
                end
                if (r_cls == LAST_CLS) begin
                    n_state = V_DONE;
                end else begin
                    n_cls = r_cls + CLS_W'(1);
                end
            end
            V_DONE: begin
                n_state = V_IDLE;
            end
            default: begin
                n_state = V_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= V_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_idx  <= n_idx;
        r_cls  <= n_cls;
        r_best <= n_best;
        r_pick <= n_pick;
        for (int k = 0; k < NUM_CLASS; k++) begin
            r_cnt[k] <= n_cnt[k];
        end
    end

    assign o_raddr       = r_idx;
    assign o_status.busy = (r_state != V_IDLE);
    assign o_status.done = (r_state == V_DONE);
    assign o_status.pick = r_pick;

endmodule

@@ rtl/track_confirm_vote.sv @@
// ----------------------------------------------------------------------------
// track_confirm_vote
// Debounce and class vote for one tracked object, one beat per frame tick.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+------------------------------
//  in      | sink      | i_in_valid / o_in_stall | present, hat/vest violation
//  out     | source    | o_out_valid / i_out_stall | is_stable, verdict, cleared
//  cfg     | sink      | i_cfg_valid / o_cfg_ready | index, data (always ready)
//
//  An accepted tick is captured, evaluated and then committed to the output
//  register once the slot is free; the input reopens in the cycle after the
//  commit. The tick that confirms a new object adds the vote walk over the
//  ring slots and then over the class counters, all on the one shared
//  incrementer and comparator of the vote unit.
//  Reset (synchronous, active low) clears the ring and loads the register
//  defaults; there is no clearing pass. A stalled output beat holds; the
//  next tick is still accepted and waits in the commit step for the slot.
// ----------------------------------------------------------------------------
module track_confirm_vote #(
    parameter int WINDOW = tcv_pkg::WINDOW_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input beats
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_present,
    input  logic              i_hat_violation,
    input  logic              i_vest_violation,
    // result beats
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_is_stable,
    output tcv_pkg::t_cls     o_verdict_class,
    output logic              o_cleared,
    // register writes
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  tcv_pkg::t_cfg_idx i_cfg_index,
    input  tcv_pkg::t_tick    i_cfg_data
);
    import tcv_pkg::*;

    localparam int PTR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(WINDOW - 1);

    // sequencer: accept -> evaluate -> (vote) -> commit
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EVAL = 4'b0010,
        S_VOTE = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    t_state           r_state, n_state;

    // configuration
    t_tick            r_confirm, r_hold;

    // track state
    logic             r_stable;
    t_tick            r_counter;
    t_cls             r_verdict;
    logic [PTR_W-1:0] r_ptr;

    // captured input beat
    logic             r_present, r_hat, r_vest;

    // output register
    logic             r_out_valid;
    logic             r_out_stable;
    t_cls             r_out_verdict;
    logic             r_out_cleared;

    // commit step next values
    logic             n_stable;
    t_tick            n_counter;
    t_cls             n_verdict;
    logic             n_clear;
    logic             n_record;

    logic             in_acc;
    logic             slot_free;
    logic             commit;
    t_tick            cnt_dec;
    logic             dec_zero;
    logic             need_vote;
    t_cls             tick_code;

    t_vote_status     vote_st;
    logic [PTR_W-1:0] vote_raddr;
    t_cls             ring_rdata;

    assign in_acc    = i_in_valid && !o_in_stall;
    assign slot_free = !r_out_valid || !i_out_stall;
    assign commit    = (r_state == S_EMIT) && slot_free;

    assign cnt_dec   = r_counter - t_tick'(1);
    assign dec_zero  = (cnt_dec == '0);
    // only the tick that promotes a new object runs the vote
    assign need_vote = r_present && !r_stable && dec_zero;

    always_comb begin
        if (r_hat && r_vest) begin
            tick_code = CLS_BOTH;
        end else if (r_hat) begin
            tick_code = CLS_HAT;
        end else if (r_vest) begin
            tick_code = CLS_VEST;
        end else begin
            tick_code = CLS_OK;
        end
    end

    // track update for the captured tick; the vote reads the ring before
    // this tick's code goes in
    always_comb begin
        n_stable  = r_stable;
        n_counter = r_counter;
        n_verdict = r_verdict;
        n_clear   = 1'b0;
        n_record  = 1'b0;
        if (r_present) begin
            n_record = 1'b1;
            if (!r_stable) begin
                if (dec_zero) begin
                    n_stable  = 1'b1;
                    n_verdict = vote_st.pick;
                    n_counter = r_hold;
                end else begin
                    n_counter = cnt_dec;
                end
            end else begin
                n_counter = r_hold;
            end
        end else if (!r_stable || dec_zero) begin
            n_clear = 1'b1;
        end else begin
            n_counter = cnt_dec;
        end
        if (n_clear) begin
            n_stable  = 1'b0;
            n_verdict = CLS_NONE;
            n_counter = r_confirm;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                n_state = need_vote ? S_VOTE : S_EMIT;
            end
            S_VOTE: begin
                if (vote_st.done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_confirm   <= CONFIRM_RST;
            r_hold      <= HOLD_RST;
            r_stable    <= 1'b0;
            r_counter   <= CONFIRM_RST;
            r_verdict   <= CLS_NONE;
            r_ptr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_CONFIRM: r_confirm <= i_cfg_data;
                    CFG_HOLD:    r_hold    <= i_cfg_data;
                    default:     ;
                endcase
            end
            if (commit) begin
                r_stable  <= n_stable;
                r_counter <= n_counter;
                r_verdict <= n_verdict;
                if (n_record) begin
                    r_ptr <= (r_ptr == LAST_PTR) ? '0 : r_ptr + PTR_W'(1);
                end
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        if (in_acc) begin
            r_present <= i_present;
            r_hat     <= i_hat_violation;
            r_vest    <= i_vest_violation;
        end
        if (commit) begin
            r_out_stable  <= n_stable;
            r_out_verdict <= n_verdict;
            r_out_cleared <= n_clear;
        end
    end

    tcv_ring #(
        .WINDOW (WINDOW),
        .PTR_W  (PTR_W)
    ) u_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clr   (commit && n_clear),
        .i_we    (commit && n_record),
        .i_waddr (r_ptr),
        .i_wdata (tick_code),
        .i_raddr (vote_raddr),
        .o_rdata (ring_rdata)
    );

    tcv_vote #(
        .WINDOW (WINDOW),
        .PTR_W  (PTR_W)
    ) u_vote (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  ((r_state == S_EVAL) && need_vote && !vote_st.busy),
        .i_rdata  (ring_rdata),
        .o_raddr  (vote_raddr),
        .o_status (vote_st)
    );

    assign o_in_stall      = (r_state != S_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign o_out_valid     = r_out_valid;
    assign o_is_stable     = r_out_stable;
    assign o_verdict_class = r_out_verdict;
    assign o_cleared       = r_out_cleared;

endmodule

@@ rtl/tcv_checker.sv @@
// ----------------------------------------------------------------------------
// tcv_checker
// Port-level checks of the track vote, bound onto the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tcv_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input logic              o_is_stable,
    input tcv_pkg::t_cls     o_verdict_class,
    input logic              o_cleared
);
    import tcv_pkg::*;

    // a stalled result beat holds
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid && $stable({o_is_stable, o_verdict_class, o_cleared}), "result beat changed under stall")

    // a cleared track reports phase new and no verdict
    `ASSERT_CLK(a_clear_zero, i_clk, i_rst_n, o_out_valid && o_cleared |-> !o_is_stable && o_verdict_class == CLS_NONE, "cleared beat carries track state")

    // a new object never carries a verdict
    `ASSERT_CLK(a_new_no_verdict, i_clk, i_rst_n, o_out_valid && !o_is_stable |-> o_verdict_class == CLS_NONE, "verdict on a new object")

    // one tick at a time: the input stalls right after an accept
    `ASSERT_CLK(a_busy_after_acc, i_clk, i_rst_n, i_in_valid && !o_in_stall |=> o_in_stall, "input accepted while busy")

    // reset empties the output register
    `ASSERT_CLK_NR(a_rst_empty, i_clk, !i_rst_n |=> !o_out_valid, "result beat after reset")

endmodule

bind track_confirm_vote tcv_checker u_tcv_checker (.*);

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the track debounce and class vote block.
// Frame ticks go in through a bursty driver. A track model inside the bench
// predicts every result beat, and a monitor checks each field as it comes
// out. The result side stalls on its own changing pattern, with long
// hold-offs so that the block backs up into its input.
// ----------------------------------------------------------------------------
module tb;
    import tcv_pkg::*;

    localparam int RING_LEN        = WINDOW_DEF;
    localparam int HOLD_OFF_CYCLES = 150;   // long receiver hold-off
    localparam int HOLD_OFF_STRIDE = 450;   // results between hold-offs
    localparam int DRAIN_CYCLES    = 40;    // drain time before the final queue check
    localparam int MAX_REPORTS     = 10;

    // register indexes past the list; the block must drop these writes
    localparam t_cfg_idx CFG_SPARE_LO = 2'd2;
    localparam t_cfg_idx CFG_SPARE_HI = 2'd3;

    typedef struct packed {
        logic present;
        logic hat;
        logic vest;
    } frame_tick_t;

    typedef struct packed {
        logic stable;
        t_cls verdict;
        logic cleared;
    } track_status_t;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_RANDOM,
        STALL_PATTERN
    } stall_mode_t;

    // ------------------------------------------------------------------------
    // DUT hookup; every input starts at a known value
    // ------------------------------------------------------------------------
    logic     i_clk            = 1'b0;
    logic     i_rst_n          = 1'b0;
    logic     i_in_valid       = 1'b0;
    logic     i_present        = 1'b0;
    logic     i_hat_violation  = 1'b0;
    logic     i_vest_violation = 1'b0;
    logic     i_out_stall      = 1'b0;
    logic     i_cfg_valid      = 1'b0;
    t_cfg_idx i_cfg_index      = CFG_CONFIRM;
    t_tick    i_cfg_data       = '0;

    logic o_in_stall;
    logic o_out_valid;
    logic o_is_stable;
    t_cls o_verdict_class;
    logic o_cleared;
    logic o_cfg_ready;

    track_confirm_vote uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_present       (i_present),
        .i_hat_violation (i_hat_violation),
        .i_vest_violation(i_vest_violation),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_is_stable     (o_is_stable),
        .o_verdict_class (o_verdict_class),
        .o_cleared       (o_cleared),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Track model: bench copy of the registers and the track state
    // ------------------------------------------------------------------------
    t_tick       cfg_confirm;
    t_tick       cfg_hold;
    logic        trk_stable;
    t_tick       trk_count;
    t_cls        trk_ring [RING_LEN];
    int unsigned trk_ptr;
    t_cls        trk_verdict;

    // bookkeeping
    frame_tick_t   tick_feed_q[$];        // ticks waiting for the driver
    track_status_t expected_status_q[$];  // predicted result beats, oldest first
    int unsigned ticks_queued   = 0;
    int unsigned ticks_accepted = 0;
    int unsigned results_seen   = 0;
    int unsigned mismatches     = 0;
    int unsigned settings_used  = 0;
    int unsigned track_clears   = 0;
    int unsigned confirmations  = 0;
    int unsigned hold_offs      = 0;
    int unsigned verdict_tally [NUM_CLASS];

    function automatic void drop_track();
        trk_stable  = 1'b0;
        trk_verdict = CLS_NONE;
        trk_count   = cfg_confirm;
        foreach (trk_ring[k]) trk_ring[k] = CLS_NONE;
    endfunction

    function automatic void reset_track_model();
        cfg_confirm = CONFIRM_RST;
        cfg_hold    = HOLD_RST;
        trk_ptr     = 0;
        foreach (verdict_tally[k]) verdict_tally[k] = 0;
        drop_track();
    endfunction

    function automatic t_cls tick_class(logic hat, logic vest);
        if (hat && vest) return CLS_BOTH;
        if (hat) return CLS_HAT;
        if (vest) return CLS_VEST;
        return CLS_OK;
    endfunction

    // most frequent code in the ring; strict > keeps the lower code on a tie
    function automatic t_cls majority_class();
        int unsigned tally [NUM_CLASS];
        int unsigned best;
        t_cls        pick;
        best = 0;
        pick = CLS_NONE;
        foreach (tally[k]) tally[k] = 0;
        for (int k = 0; k < RING_LEN; k++)
            if (trk_ring[k] < NUM_CLASS) tally[trk_ring[k]]++;
        for (int k = 0; k < NUM_CLASS; k++) begin
            if (tally[k] > best) begin
                best = tally[k];
                pick = t_cls'(k);
            end
        end
        return pick;
    endfunction

    // one frame tick through the track; returns the beat it must produce
    function automatic track_status_t advance_track(frame_tick_t t);
        track_status_t s;
        s.cleared = 1'b0;
        if (t.present) begin
            if (!trk_stable) begin
                trk_count = trk_count - 8'd1;   // 8-bit wrap on purpose
                if (trk_count == '0) begin
                    // vote sees the ring before this tick's code lands
                    trk_stable  = 1'b1;
                    trk_verdict = majority_class();
                    trk_count   = cfg_hold;
                    confirmations++;
                    verdict_tally[trk_verdict]++;
                end
            end else begin
                trk_count = cfg_hold;
            end
            trk_ring[trk_ptr] = tick_class(t.hat, t.vest);
            trk_ptr = (trk_ptr + 1) % RING_LEN;
        end else if (!trk_stable) begin
            drop_track();                      // new and absent: gone at once
            s.cleared = 1'b1;
        end else begin
            trk_count = trk_count - 8'd1;
            if (trk_count == '0) begin
                drop_track();
                s.cleared = 1'b1;
            end
        end
        if (s.cleared) track_clears++;
        s.stable  = trk_stable;
        s.verdict = trk_verdict;
        return s;
    endfunction

    // ------------------------------------------------------------------------
    // Driver: bursts of beats with random gaps, fed from tick_feed_q.
    // Prediction happens at the edge where the beat is taken.
    // ------------------------------------------------------------------------
    int unsigned burst_left = 0;
    int unsigned gap_left   = 0;

    always @(posedge i_clk) begin
        logic        offer;
        frame_tick_t nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            offer = i_in_valid;
            if (i_in_valid && !o_in_stall) begin
                expected_status_q.push_back(advance_track(
                    frame_tick_t'({i_present, i_hat_violation, i_vest_violation})));
                ticks_accepted++;
                offer = 1'b0;
            end
            // a stalled beat keeps its payload; only refill an empty slot
            if (!offer) begin
                if (gap_left != 0) begin
                    gap_left--;
                end else if (tick_feed_q.size() != 0) begin
                    nxt = tick_feed_q.pop_front();
                    i_present        <= nxt.present;
                    i_hat_violation  <= nxt.hat;
                    i_vest_violation <= nxt.vest;
                    offer = 1'b1;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        // half the bursts run straight into the next one
                        burst_left = $urandom_range(1, 32);
                        gap_left   = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
            i_in_valid <= offer;
        end
    end

    // ------------------------------------------------------------------------
    // Receiver stall: picks a new mode at random (none / random /
    // rotating bit pattern); after 200 results and then every HOLD_OFF_STRIDE
    // results it holds off so the block backs up and stalls its input.
    // ------------------------------------------------------------------------
    int unsigned hold_left      = 0;
    int unsigned next_hold_mark = 200;
    int unsigned mode_left      = 0;
    stall_mode_t stall_mode     = STALL_NONE;
    logic [7:0]  stall_pattern  = 8'h00;

    always @(posedge i_clk) begin
        logic stall;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (hold_left != 0) begin
                hold_left--;
                stall = 1'b1;
            end else if (results_seen >= next_hold_mark) begin
                hold_left      = HOLD_OFF_CYCLES - 1;
                next_hold_mark = next_hold_mark + HOLD_OFF_STRIDE;
                hold_offs++;
                stall = 1'b1;
            end else begin
                if (mode_left == 0) begin
                    mode_left     = $urandom_range(16, 96);
                    stall_mode    = stall_mode_t'($urandom_range(0, 2));
                    stall_pattern = 8'($urandom_range(0, 255));
                end else begin
                    mode_left--;
                end
                case (stall_mode)
                    STALL_NONE: begin
                        stall = 1'b0;
                    end
                    STALL_RANDOM: begin
                        stall = ($urandom_range(0, 99) < 40);
                    end
                    default: begin
                        stall         = stall_pattern[0];
                        stall_pattern = {stall_pattern[0], stall_pattern[7:1]};
                    end
                endcase
            end
            i_out_stall <= stall;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: each accepted result beat against the oldest prediction
    // ------------------------------------------------------------------------
    function automatic void flag_mismatch(string what);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("result %0d: %s", results_seen, what);
    endfunction

    always @(posedge i_clk) begin
        track_status_t want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_status_q.size() == 0) begin
                flag_mismatch("result beat with no tick pending");
            end else begin
                want = expected_status_q.pop_front();
                if (o_is_stable !== want.stable)
                    flag_mismatch($sformatf("is_stable expected %0b got %0b",
                                            want.stable, o_is_stable));
                if (o_verdict_class !== want.verdict)
                    flag_mismatch($sformatf("verdict_class expected %0d got %0d",
                                            want.verdict, o_verdict_class));
                if (o_cleared !== want.cleared)
                    flag_mismatch($sformatf("cleared expected %0b got %0b",
                                            want.cleared, o_cleared));
                results_seen++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic void feed(logic p, logic h, logic v);
        tick_feed_q.push_back('{present: p, hat: h, vest: v});
        ticks_queued++;
    endfunction

    // every queued tick has come back as a beat; then a short pause
    task automatic settle();
        while (results_seen < ticks_queued) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // leaves valid high; the caller lowers it after the last write
    task automatic write_reg(t_cfg_idx idx, t_tick val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_CONFIRM: cfg_confirm = val;
            CFG_HOLD:    cfg_hold    = val;
            default:     ;
        endcase
    endtask

    task automatic program_track(t_tick confirm, t_tick hold, logic with_spares);
        settle();
        write_reg(CFG_CONFIRM, confirm);
        write_reg(CFG_HOLD, hold);
        if (with_spares) begin
            write_reg(CFG_SPARE_LO, 8'h00);
            write_reg(CFG_SPARE_HI, 8'hFF);
        end
        i_cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // Track episodes: a present run (usually long enough to confirm, with a
    // dominant class and some scatter) then an absent run (about half long
    // enough to clear). Later episodes get absent blips mid-run.
    task automatic feed_episodes(int unsigned budget);
        int unsigned added;
        int unsigned run;
        logic [1:0]  usual;
        logic        first;
        added = 0;
        first = 1'b1;
        while (added < budget) begin
            usual = 2'($urandom_range(0, 3));
            if (first || $urandom_range(0, 9) < 7)
                run = cfg_confirm + $urandom_range(0, 6);
            else
                run = $urandom_range(1, cfg_confirm);
            for (int k = 0; k < run; k++) begin
                if (!first && $urandom_range(0, 24) == 0)
                    feed(1'b0, 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)));
                else if ($urandom_range(0, 99) < 65)
                    feed(1'b1, usual[1], usual[0]);
                else
                    feed(1'b1, 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)));
            end
            added += run;
            if ($urandom_range(0, 1) == 0)
                run = cfg_hold + $urandom_range(0, 3);
            else
                run = $urandom_range(1, cfg_hold);
            for (int k = 0; k < run; k++)
                feed(1'b0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            added += run;
            first = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        reset_track_model();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset registers (5 / 30)
        feed(1'b0, 1'b1, 1'b1);     // new and absent: cleared at once
        feed(1'b1, 1'b1, 1'b1);
        feed(1'b1, 1'b1, 1'b0);
        feed(1'b1, 1'b0, 1'b1);
        feed(1'b1, 1'b0, 1'b0);
        feed(1'b1, 1'b1, 1'b1);     // confirms; empty slots win the vote
        feed(1'b0, 1'b0, 1'b0);     // stable absent, hold count runs
        feed(1'b1, 1'b0, 1'b1);     // stable present reloads hold

        // shortest hold; confirm 9 so the vote sees a full ring
        program_track(8'd9, 8'd1, 1'b0);
        feed(1'b0, 1'b0, 1'b0);     // old hold of 30 still loaded
        feed(1'b1, 1'b1, 1'b1);     // reload picks up hold of 1
        feed(1'b0, 1'b0, 1'b0);     // stable object cleared after hold
        repeat (4) feed(1'b1, 1'b1, 1'b1);
        repeat (4) feed(1'b1, 1'b0, 1'b0);
        feed(1'b1, 1'b1, 1'b0);     // 4 both vs 4 ok: tie goes to ok

        // largest values, plus writes to unused indexes
        program_track(8'd255, 8'd255, 1'b1);
        feed(1'b0, 1'b1, 1'b0);     // hold of 1 still loaded: clears
        feed(1'b1, 1'b0, 1'b1);
        feed(1'b0, 1'b0, 1'b1);     // new object dropped mid-count

        // random part: the two extreme settings, then small ones
        program_track(8'd255, 8'd3, 1'b0);
        feed_episodes(270);
        program_track(8'd1, 8'd255, 1'b0);
        feed_episodes(270);
        repeat (5) begin
            program_track(8'($urandom_range(1, 10)), 8'($urandom_range(1, 12)), 1'b0);
            feed_episodes(75);
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_status_q.size() != 0)
            flag_mismatch($sformatf("%0d predicted beats never arrived",
                                    expected_status_q.size()));

        $display("Checked %0d frame ticks over %0d register settings: %0d clears,",
                 ticks_accepted, settings_used + 1, track_clears);
        $display("  %0d confirms, %0d hold-offs; verdicts none/ok/vest/hat/both: %0d/%0d/%0d/%0d/%0d.",
                 confirmations, hold_offs,
                 verdict_tally[CLS_NONE], verdict_tally[CLS_OK], verdict_tally[CLS_VEST],
                 verdict_tally[CLS_HAT], verdict_tally[CLS_BOTH]);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // watchdog: several times the slowest legal run
    initial begin
        #5000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
